// ----- rtl/core/bba_pkg.sv -----
package bba_pkg;

  localparam int MIN_BLOCK_LOG2_DEF = 10;
  localparam int LEVELS_DEF = 8;
  localparam int LVL_W = 4;
  localparam int SIZE_W = 18;
  localparam int OFF_W = 17;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REALLOC = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] old_size;
    logic [OFF_W-1:0] offset;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0] result_offset;
    logic [STAT_W-1:0] status;
  } rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_REL_TOG, S_REL_DEC, S_REL_PUSH,
    S_UNL_HEAD, S_UNL_RD, S_UNL_WALK, S_UNL_FIX,
    S_ALC_FIND, S_ALC_POP, S_ALC_POPW, S_ALC_SPLIT, S_ALC_FIN, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic check;
    logic rel_tog;
    logic rel_dec;
    logic rel_push;
    logic unl_head;
    logic unl_rd;
    logic unl_walk;
    logic unl_fix;
    logic alc_start;
    logic alc_find;
    logic alc_pop;
    logic alc_popw;
    logic alc_split;
    logic alc_fin;
    logic done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic bad;
    logic need_rel;
    logic need_alc;
    logic rel_stop;
    logic unl_none;
    logic unl_hit_head;
    logic unl_found;
    logic unl_give_up;
    logic find_ok;
    logic find_fail;
    logic split_more;
    logic split_fail;
  } sts_t;

endpackage

// ----- rtl/core/bba_ctrl.sv -----
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          cfg_we,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd,
  output logic          busy
);
  import bba_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst || cfg_we) state <= S_CLEAR;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
      S_IDLE: if (start) state_next = S_CHECK;
      S_CHECK: begin
        if (sts.bad) state_next = S_DONE;
        else if (sts.need_rel) state_next = S_REL_TOG;
        else if (sts.need_alc) state_next = S_ALC_FIND;
        else state_next = S_DONE;
      end
      S_REL_TOG: state_next = sts.rel_stop ? S_REL_PUSH : S_UNL_HEAD;
      S_UNL_HEAD: begin
        if (sts.unl_hit_head) state_next = S_REL_DEC;
        else if (sts.unl_none) state_next = S_REL_DEC;
        else state_next = S_UNL_RD;
      end
      S_UNL_RD: state_next = S_UNL_WALK;
      S_UNL_WALK: begin
        if (sts.unl_found) state_next = S_UNL_FIX;
        else if (sts.unl_give_up) state_next = S_REL_DEC;
        else state_next = S_UNL_RD;
      end
      S_UNL_FIX: state_next = S_REL_DEC;
      S_REL_DEC: state_next = S_REL_TOG;
      S_REL_PUSH: state_next = sts.need_alc ? S_ALC_FIND : S_DONE;
      S_ALC_FIND: begin
        if (sts.find_ok) state_next = S_ALC_POP;
        else if (sts.find_fail) state_next = S_DONE;
      end
      S_ALC_POP: state_next = S_ALC_POPW;
      S_ALC_POPW: begin
        if (!sts.split_more) state_next = S_ALC_FIN;
        else if (sts.split_fail) state_next = S_DONE;
        else state_next = S_ALC_SPLIT;
      end
      S_ALC_SPLIT: state_next = S_ALC_POP;
      S_ALC_FIN: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: cmd.load = start;
      S_CHECK: begin
        cmd.check = 1'b1;
        cmd.alc_start = !sts.bad && !sts.need_rel && sts.need_alc;
      end
      S_REL_TOG: cmd.rel_tog = 1'b1;
      S_UNL_HEAD: cmd.unl_head = 1'b1;
      S_UNL_RD: cmd.unl_rd = 1'b1;
      S_UNL_WALK: cmd.unl_walk = 1'b1;
      S_UNL_FIX: cmd.unl_fix = 1'b1;
      S_REL_DEC: cmd.rel_dec = 1'b1;
      S_REL_PUSH: begin
        cmd.rel_push = 1'b1;
        cmd.alc_start = sts.need_alc;
      end
      S_ALC_FIND: cmd.alc_find = 1'b1;
      S_ALC_POP: cmd.alc_pop = 1'b1;
      S_ALC_POPW: cmd.alc_popw = 1'b1;
      S_ALC_SPLIT: cmd.alc_split = 1'b1;
      S_ALC_FIN: cmd.alc_fin = 1'b1;
      S_DONE: cmd.done = 1'b1;
      default: cmd = '0;
    endcase
  end

  // a result is only raised out of the done state
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.done |-> busy) else $error("done while idle");
  a_clear_no_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> busy) else $error("idle during clear");
  a_done_then_idle: assert property (@(posedge clk) disable iff (rst || cfg_we)
    cmd.done |=> (state == S_IDLE)) else $error("done not followed by idle");

endmodule

// ----- rtl/core/bba_dp.sv -----
module bba_dp #(
  parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2_DEF,
  parameter int LEVELS = bba_pkg::LEVELS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [bba_pkg::LVL_W-1:0] cfg_data,
  input  bba_pkg::req_t            req,
  input  bba_pkg::cmd_t            cmd,
  output bba_pkg::sts_t            sts,
  output logic                     strobe,
  output bba_pkg::rsp_t            rsp
);
  import bba_pkg::*;

  localparam int BW = LEVELS;                 // block number width
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int BLOCKS = (1 << LEVELS) - 1;
  localparam int PAIRS = 1 << (LEVELS - 1);
  localparam int PW = (LEVELS > 1) ? LEVELS - 1 : 1;
  localparam int PLW = MIN_BLOCK_LOG2 + LEVELS; // pool width
  localparam logic [BW-1:0] NIL = BW'(BLOCKS);

  // free list memory and heads, pair bits
  logic [BW-1:0] next_mem [BLOCKS];
  logic [BW-1:0] head [LEVELS];
  logic [PAIRS-1:0] pair;
  logic [LVL_W-1:0] liu;
  logic [BW-1:0] clr_cnt;

  // request registers
  req_t r;
  logic [LW-1:0] lvl, alvl, j;
  logic [BW-1:0] blk, prev, cur, rd_data, split_b;
  logic [BW:0] steps;
  logic split_link;
  logic [OFF_W-1:0] res;
  logic [STAT_W-1:0] stat;

  // memory port control
  logic          we;
  logic [BW-1:0] waddr, wdata, raddr;

  logic [PLW:0] pool;
  assign pool = (PLW+1)'(1) << (MIN_BLOCK_LOG2 + 32'(liu) - 1);

  function automatic logic [LW-1:0] level_of(input logic [SIZE_W-1:0] sz,
                                             input logic [LVL_W-1:0] n);
    logic [LW-1:0] l;
    l = '0;
    for (int i = 1; i < LEVELS; i++) begin
      if (i < 32'(n) && ({(PLW+1)'(0)} + ((PLW+1)'(1) << (MIN_BLOCK_LOG2 + 32'(n) - 1 - i)))
          >= (PLW+1)'(sz))
        l = LW'(i);
    end
    return l;
  endfunction

  logic [LW-1:0] lvl_new, lvl_old;
  logic size_bad, old_bad, off_bad;
  logic [PLW:0] bs_old;
  logic [BW-1:0] blk_old;
  assign lvl_new = level_of(r.size, liu);
  assign lvl_old = level_of((r.mode == MODE_FREE) ? r.size : r.old_size, liu);
  assign size_bad = (r.size == '0) || ((PLW+1)'(r.size) > pool);
  assign old_bad = (r.old_size == '0) || ((PLW+1)'(r.old_size) > pool);
  assign bs_old = pool >> lvl_old;
  assign off_bad = ((PLW+1)'(r.offset) >= pool) ||
                   (((PLW+1)'(r.offset) & (bs_old - 1'b1)) != '0);
  assign blk_old = BW'(((PLW+1)'(r.offset) >> (MIN_BLOCK_LOG2 + 32'(liu) - 1
                   - 32'(lvl_old)))) + BW'((1 << lvl_old) - 1);

  logic bad_c, rel_c;
  always_comb begin
    bad_c = 1'b0; rel_c = 1'b0;
    case (r.mode)
      MODE_ALLOC: bad_c = size_bad;
      MODE_FREE: begin bad_c = size_bad || off_bad; rel_c = 1'b1; end
      MODE_REALLOC: begin
        bad_c = size_bad || old_bad || off_bad;
        rel_c = (lvl_new != lvl_old);
      end
      default: bad_c = 1'b1;
    endcase
  end

  logic [PW-1:0] pidx;
  logic [BW:0] blk_p1;
  assign blk_p1 = {1'b0, blk} + 1'b1;
  assign pidx = PW'(blk_p1 >> 1);
  logic [BW-1:0] buddy;
  assign buddy = blk[0] ? blk + 1'b1 : blk - 1'b1;

  // left child of the block being split
  logic [BW-1:0] split_c;
  logic [BW:0] split_c2;
  assign split_c2 = {split_b, 1'b1};
  assign split_c = split_c2[BW-1:0];

  // status to controller
  always_comb begin
    sts = '0;
    sts.clear_last = (clr_cnt == NIL - 1'b1) || (BLOCKS == 1);
    sts.bad = bad_c;
    sts.need_rel = rel_c;
    sts.need_alc = (r.mode == MODE_ALLOC) || ((r.mode == MODE_REALLOC) && rel_c);
    sts.rel_stop = (blk == '0) || (lvl == '0) || !pair[pidx];
    sts.unl_hit_head = (head[lvl] == buddy);
    sts.unl_none = (head[lvl] == NIL);
    sts.unl_found = (rd_data == buddy);
    sts.unl_give_up = (rd_data == NIL) || (steps >= (BW+1)'(BLOCKS));
    sts.find_ok = (head[j] != NIL);
    sts.find_fail = (head[j] == NIL) && (j == '0);
    sts.split_more = (j != alvl);
    sts.split_fail = ({1'b0, split_c2} + 1'b1) >= (BW+2)'(BLOCKS);
  end

  // memory port steering
  always_comb begin
    we = 1'b0; waddr = blk; wdata = NIL; raddr = cur;
    if (cmd.clear_step) begin
      we = 1'b1; waddr = clr_cnt;
    end else if (cmd.unl_head) begin
      raddr = buddy;
      if (head[lvl] == buddy) begin
        we = 1'b1; waddr = buddy; wdata = NIL;
      end
    end else if (cmd.unl_rd) begin
      raddr = cur;
    end else if (cmd.unl_walk) begin
      // buddy found in the list: it leaves with a null link
      we = (rd_data == buddy); waddr = buddy; wdata = NIL;
    end else if (cmd.unl_fix) begin
      we = 1'b1; waddr = prev; wdata = buddy_next;
    end else if (cmd.rel_push) begin
      we = 1'b1; waddr = blk; wdata = head[lvl];
    end else if (cmd.alc_pop) begin
      raddr = head[j];
    end else if (cmd.alc_popw) begin
      we = 1'b1; waddr = split_b; wdata = NIL;
    end else if (cmd.alc_split) begin
      we = 1'b1; waddr = split_c + 1'b1; wdata = head[j + 1'b1];
    end
  end

  // second read port follows the buddy of the current block
  logic [BW-1:0] buddy_next;

  always_ff @(posedge clk) begin
    if (we) next_mem[waddr] <= wdata;
    rd_data <= next_mem[raddr];
    buddy_next <= next_mem[buddy];
  end

  // control and list state
  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst || cfg_we) begin
      if (rst) liu <= LVL_W'(LEVELS);
      else if (cfg_data == '0) liu <= LVL_W'(1);
      else if (32'(cfg_data) > LEVELS) liu <= LVL_W'(LEVELS);
      else liu <= cfg_data;
      for (int i = 0; i < LEVELS; i++) head[i] <= NIL;
      head[0] <= '0;
      pair <= '0;
      clr_cnt <= '0;
      split_link <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.load) r <= req;
      if (cmd.check) begin
        lvl <= lvl_old; blk <= blk_old; res <= '0; stat <= ST_OK;
        alvl <= lvl_new;
        if (bad_c) stat <= ST_BAD;
        else if (r.mode == MODE_REALLOC && !rel_c) res <= r.offset;
      end
      if (cmd.alc_start) j <= lvl_new;
      if (cmd.rel_tog) pair[pidx] <= ~pair[pidx];
      if (cmd.unl_head) begin
        if (head[lvl] == buddy) head[lvl] <= buddy_next;
        cur <= head[lvl]; prev <= head[lvl];
        steps <= '0;
      end
      if (cmd.unl_rd) steps <= steps;
      if (cmd.unl_walk && !(rd_data == buddy) && !sts.unl_give_up) begin
        prev <= rd_data; cur <= rd_data; steps <= steps + 1'b1;
      end
      if (cmd.rel_dec) begin
        blk <= BW'((blk - 1'b1) >> 1); lvl <= lvl - 1'b1;
      end
      if (cmd.rel_push) head[lvl] <= blk;
      if (cmd.alc_find && head[j] == NIL) begin
        if (j == '0) stat <= ST_OOM;
        else j <= j - 1'b1;
      end
      if (cmd.alc_pop) begin
        split_b <= head[j];
        pair[PW'(({1'b0, head[j]} + 1'b1) >> 1)] <= ~pair[PW'(({1'b0, head[j]} + 1'b1) >> 1)];
      end
      // a freshly split left child always links to its right sibling
      if (cmd.alc_popw) begin
        head[j] <= split_link ? split_b + 1'b1 : rd_data;
        split_link <= 1'b0;
        if (j != alvl && sts.split_fail) stat <= ST_OOM;
      end
      if (cmd.alc_split) begin
        head[j + 1'b1] <= split_c;
        j <= j + 1'b1;
        split_link <= 1'b1;
      end
      if (cmd.alc_fin)
        res <= OFF_W'(((PLW+1)'(split_b - BW'((1 << alvl) - 1))) <<
               (MIN_BLOCK_LOG2 + 32'(liu) - 1 - 32'(alvl)));
      if (cmd.done) begin
        strobe <= 1'b1;
        rsp.status <= stat;
        rsp.result_offset <= (stat == ST_OK) ? res : '0;
      end
    end
  end

  a_strobe_once: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("two strobes in a row");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && rsp.status != ST_OK) |-> (rsp.result_offset == '0))
    else $error("offset on error");
  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    cmd.alc_fin |-> (j == alvl)) else $error("split ended at wrong level");

endmodule

// ----- rtl/core/buddy_block_allocator_core.sv -----
// buddy block allocator core
// command channel: drive mode, size, old_size, offset in req and pulse start
// while busy is low; the word is taken at that edge and busy rises.
// result channel: one word per request on rsp, marked by strobe for one cycle;
// the receiver cannot stall it, it must take the word at once.
// cfg_we with cfg_data writes levels_in_use and restarts the allocator.
// the work after the accepting edge is data dependent: a rejected request or
// a reallocate that keeps its level goes from the check straight to the result.
// a free toggles a pair bit per level, unlinks the buddy of each merged level
// from the list head or by a walk down the list, then pushes the merged block.
// an allocate searches from its level toward larger blocks for a free one, pops
// it and splits level by level; a moving reallocate does a free then this.
// busy drops in the result cycle, so the next start can come in that cycle;
// one request is in flight at a time, set by the sequential list walks.
// after reset or a config write the free list memory is cleared one entry per
// cycle, all 2^LEVELS - 1 entries, with busy high.
module buddy_block_allocator_core #(
  parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2_DEF,
  parameter int LEVELS = bba_pkg::LEVELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  bba_pkg::req_t             req,
  output logic                      strobe,
  output bba_pkg::rsp_t             rsp,
  input  logic                      cfg_we,
  input  logic [bba_pkg::LVL_W-1:0] cfg_data
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_we(cfg_we),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  bba_dp #(.MIN_BLOCK_LOG2(MIN_BLOCK_LOG2), .LEVELS(LEVELS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req), .cmd(cmd), .sts(sts), .strobe(strobe), .rsp(rsp)
  );

endmodule
